FILE: sv/ffha_pkg.sv
package ffha_pkg;

   localparam int MAX_BLOCKS   = 64;
   localparam int HEADER_BYTES = 16;

   localparam int IDX_W  = $clog2(MAX_BLOCKS);
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int STEP_W = 4;
   localparam int PADDR_W = 3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ZERO    = 2'd1;
   localparam logic [1:0] ST_NOSPACE = 2'd2;
   localparam logic [1:0] ST_UNKNOWN = 2'd3;

   localparam logic REQ_ALLOC   = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   // microprogram step addresses
   localparam logic [STEP_W-1:0] S_IDLE   = 4'd0;
   localparam logic [STEP_W-1:0] S_CHECK  = 4'd1;
   localparam logic [STEP_W-1:0] S_SCAN0  = 4'd2;
   localparam logic [STEP_W-1:0] S_SCAN   = 4'd3;
   localparam logic [STEP_W-1:0] S_MISS   = 4'd4;
   localparam logic [STEP_W-1:0] S_APPEND = 4'd5;
   localparam logic [STEP_W-1:0] S_HIT    = 4'd6;
   localparam logic [STEP_W-1:0] S_NOP    = 4'd7;
   localparam logic [STEP_W-1:0] S_UNK    = 4'd8;
   localparam logic [STEP_W-1:0] S_FULL   = 4'd9;
   localparam logic [STEP_W-1:0] S_RESULT = 4'd10;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_READ,
      ACT_APPEND,
      ACT_MARK,
      ACT_SET_NOP,
      ACT_SET_UNK,
      ACT_SET_FULL,
      ACT_EMIT
   } act_type;

   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_IS_NOP,
      C_COUNT_ZERO,
      C_MATCH,
      C_IDX_LT_COUNT,
      C_IS_REL,
      C_NO_ROOM,
      C_RSP_BUSY
   } cond_type;

   typedef struct packed {
      act_type           act;
      cond_type          cond_a;
      logic [STEP_W-1:0] target_a;
      cond_type          cond_b;
      logic [STEP_W-1:0] target_b;
   } ucode_word_type;

   typedef struct packed {
      logic is_nop;
      logic count_zero;
      logic match;
      logic idx_lt_count;
      logic is_rel;
      logic no_room;
   } dp_flags_type;

   typedef struct packed {
      dp_flags_type dp;
      logic         no_req;
      logic         rsp_busy;
   } ucode_flags_type;

   typedef struct packed {
      logic [31:0] start;
      logic [31:0] size;
      logic        free;
   } entry_type;

   function automatic ucode_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_word_type w;
      w = '{ACT_NONE, C_ALWAYS, S_IDLE, C_NEVER, S_IDLE};
      unique case (step)
         S_IDLE:   w = '{ACT_LOAD,     C_NO_REQ,     S_IDLE,   C_NEVER,        S_IDLE};
         S_CHECK:  w = '{ACT_NONE,     C_IS_NOP,     S_NOP,    C_COUNT_ZERO,   S_MISS};
         S_SCAN0:  w = '{ACT_READ,     C_NEVER,      S_IDLE,   C_NEVER,        S_IDLE};
         S_SCAN:   w = '{ACT_READ,     C_MATCH,      S_HIT,    C_IDX_LT_COUNT, S_SCAN};
         S_MISS:   w = '{ACT_NONE,     C_IS_REL,     S_UNK,    C_NO_ROOM,      S_FULL};
         S_APPEND: w = '{ACT_APPEND,   C_ALWAYS,     S_RESULT, C_NEVER,        S_IDLE};
         S_HIT:    w = '{ACT_MARK,     C_ALWAYS,     S_RESULT, C_NEVER,        S_IDLE};
         S_NOP:    w = '{ACT_SET_NOP,  C_ALWAYS,     S_RESULT, C_NEVER,        S_IDLE};
         S_UNK:    w = '{ACT_SET_UNK,  C_ALWAYS,     S_RESULT, C_NEVER,        S_IDLE};
         S_FULL:   w = '{ACT_SET_FULL, C_NEVER,      S_IDLE,   C_NEVER,        S_IDLE};
         S_RESULT: w = '{ACT_EMIT,     C_RSP_BUSY,   S_RESULT, C_ALWAYS,       S_IDLE};
         default:  w = '{ACT_NONE,     C_ALWAYS,     S_IDLE,   C_NEVER,        S_IDLE};
      endcase
      return w;
   endfunction

endpackage

FILE: sv/ffha_if.sv
interface ffha_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [31:0] req_size;
   logic [31:0] release_addr;

   modport source (output valid, output req_type, output req_size, output release_addr,
                   input ready);
   modport sink (input valid, input req_type, input req_size, input release_addr,
                 output ready);
endinterface

interface ffha_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] block_addr;

   modport source (output valid, output status, output block_addr, input ready);
   modport sink (input valid, input status, input block_addr, output ready);
endinterface

FILE: sv/ffha_ucode.sv
module ffha_ucode
   import ffha_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  ucode_flags_type flags,
   output ucode_word_type  word
);

   logic [STEP_W-1:0] step_ff, step_in;

   function automatic logic test(input cond_type c, input ucode_flags_type f);
      logic r;
      r = 1'b0;
      unique case (c)
         C_NEVER:        r = 1'b0;
         C_ALWAYS:       r = 1'b1;
         C_NO_REQ:       r = f.no_req;
         C_IS_NOP:       r = f.dp.is_nop;
         C_COUNT_ZERO:   r = f.dp.count_zero;
         C_MATCH:        r = f.dp.match;
         C_IDX_LT_COUNT: r = f.dp.idx_lt_count;
         C_IS_REL:       r = f.dp.is_rel;
         C_NO_ROOM:      r = f.dp.no_room;
         C_RSP_BUSY:     r = f.rsp_busy;
         default:        r = 1'b0;
      endcase
      return r;
   endfunction

   assign word = ucode_rom(step_ff);

   always_comb begin
      if (test(word.cond_a, flags)) begin
         step_in = word.target_a;
      end else if (test(word.cond_b, flags)) begin
         step_in = word.target_b;
      end else begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

FILE: sv/ffha_datapath.sv
module ffha_datapath
   import ffha_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  act_type      act,
   input  logic         take,
   input  logic         in_type,
   input  logic [31:0]  in_size,
   input  logic [31:0]  in_addr,
   input  logic [31:0]  heap_limit,
   input  logic         base_wr,
   input  logic [31:0]  base_val,
   output dp_flags_type flags,
   output logic [1:0]   res_status,
   output logic [31:0]  res_addr
);

   localparam logic [33:0] HDR34 = 34'(HEADER_BYTES);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCKS);

   entry_type mem [MAX_BLOCKS];

   logic             type_ff;
   logic [31:0]      size_ff;
   logic [31:0]      addr_ff;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      break_ff, break_in;
   logic [IDX_W-1:0] data_idx_ff;
   logic [IDX_W-1:0] hold_idx_ff;
   entry_type        rd_ff;
   entry_type        hold_ff;
   logic [1:0]       status_ff, status_in;
   logic [31:0]      raddr_ff, raddr_in;

   logic        mem_we;
   logic [IDX_W-1:0] mem_wa;
   entry_type   mem_wd;
   logic        rd_en;
   logic [33:0] end_addr;

   assign end_addr = {2'b00, break_ff} + {2'b00, size_ff} + HDR34;
   assign rd_en    = (act == ACT_READ) && (idx_ff < count_ff);

   assign flags.is_nop       = type_ff ? (addr_ff == 32'd0) : (size_ff == 32'd0);
   assign flags.count_zero   = (count_ff == '0);
   assign flags.match        = type_ff
      ? (({1'b0, rd_ff.start} + HDR34[32:0]) == {1'b0, addr_ff})
      : (rd_ff.free && (rd_ff.size >= size_ff));
   assign flags.idx_lt_count = (idx_ff < count_ff);
   assign flags.is_rel       = type_ff;
   assign flags.no_room      = (count_ff == MAX_CNT) || (end_addr > {2'b00, heap_limit});

   assign res_status = status_ff;
   assign res_addr   = raddr_ff;

   always_comb begin
      mem_we    = 1'b0;
      mem_wa    = hold_idx_ff;
      mem_wd    = hold_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      break_in  = break_ff;
      status_in = status_ff;
      raddr_in  = raddr_ff;
      unique case (act)
         ACT_LOAD: begin
            idx_in = '0;
         end
         ACT_READ: begin
            if (idx_ff < count_ff) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ACT_APPEND: begin
            mem_we    = 1'b1;
            mem_wa    = count_ff[IDX_W-1:0];
            mem_wd    = '{start: break_ff, size: size_ff, free: 1'b0};
            count_in  = count_ff + 1'b1;
            break_in  = end_addr[31:0];
            status_in = ST_OK;
            raddr_in  = break_ff + HDR34[31:0];
         end
         ACT_MARK: begin
            mem_we      = 1'b1;
            mem_wd.free = type_ff;
            status_in   = ST_OK;
            raddr_in    = type_ff ? 32'd0 : hold_ff.start + HDR34[31:0];
         end
         ACT_SET_NOP: begin
            status_in = type_ff ? ST_OK : ST_ZERO;
            raddr_in  = 32'd0;
         end
         ACT_SET_UNK: begin
            status_in = ST_UNKNOWN;
            raddr_in  = 32'd0;
         end
         ACT_SET_FULL: begin
            status_in = ST_NOSPACE;
            raddr_in  = 32'd0;
         end
         default: begin
         end
      endcase
      // break follows heap_base while the table is empty
      if (base_wr && (count_ff == '0)) begin
         break_in = base_val;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_ff <= mem[idx_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         break_ff <= 32'd0;
      end else begin
         count_ff <= count_in;
         break_ff <= break_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      status_ff <= status_in;
      raddr_ff  <= raddr_in;
      if (take) begin
         type_ff <= in_type;
         size_ff <= in_size;
         addr_ff <= in_addr;
      end
      if (act == ACT_READ) begin
         hold_ff     <= rd_ff;
         hold_idx_ff <= data_idx_ff;
         data_idx_ff <= idx_ff[IDX_W-1:0];
      end
   end

endmodule

FILE: sv/first_fit_heap_allocator.sv
// First-fit heap allocator. An allocate item scans the block table in creation order,
// one entry per cycle through the table's single read port, and takes the first free
// block that is large enough; if none fits it appends a block at the heap break, or
// reports no space when the table is full or the block would pass heap_limit. A
// release item scans the same way for the block with that payload address. A zero
// size or a release of address zero skips the scan. One item is in work at a time;
// the result register lets the next item be taken while a result waits. heap_base
// and heap_limit are at byte addresses 0 and 4.
module first_fit_heap_allocator
   import ffha_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   ffha_req_if.sink           req_if,
   ffha_rsp_if.source         rsp_if,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam logic REG_HEAP_BASE  = 1'b0;
   localparam logic REG_HEAP_LIMIT = 1'b1;

   logic [31:0] base_ff;
   logic [31:0] limit_ff;
   logic        cfg_wr;
   logic        base_wr;

   ucode_word_type  word;
   ucode_flags_type uflags;
   dp_flags_type    dflags;
   logic            take;
   logic [1:0]      res_status;
   logic [31:0]     res_addr;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [31:0] rsp_addr_ff;
   logic        rsp_busy;

   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite;
   assign base_wr = cfg_wr && (paddr[2] == REG_HEAP_BASE);
   assign prdata  = (paddr[2] == REG_HEAP_LIMIT) ? limit_ff : base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= 32'd0;
         limit_ff <= 32'hFFFF_FFFF;
      end else if (cfg_wr) begin
         if (paddr[2] == REG_HEAP_BASE) begin
            base_ff <= pwdata;
         end else begin
            limit_ff <= pwdata;
         end
      end
   end

   assign req_if.ready = (word.act == ACT_LOAD);
   assign take         = req_if.valid && req_if.ready;
   assign rsp_busy     = rsp_valid_ff && !rsp_if.ready;

   assign uflags.dp       = dflags;
   assign uflags.no_req   = !req_if.valid;
   assign uflags.rsp_busy = rsp_busy;

   ffha_ucode u_ucode (
      .clock (clock),
      .reset (reset),
      .flags (uflags),
      .word  (word)
   );

   ffha_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .act        (word.act),
      .take       (take),
      .in_type    (req_if.req_type),
      .in_size    (req_if.req_size),
      .in_addr    (req_if.release_addr),
      .heap_limit (limit_ff),
      .base_wr    (base_wr),
      .base_val   (pwdata),
      .flags      (dflags),
      .res_status (res_status),
      .res_addr   (res_addr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((word.act == ACT_EMIT) && !rsp_busy) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((word.act == ACT_EMIT) && !rsp_busy) begin
         rsp_status_ff <= res_status;
         rsp_addr_ff   <= res_addr;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.block_addr = rsp_addr_ff;

endmodule

FILE: sv/ffha_checker.sv
module ffha_checker
   import ffha_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_block_addr
);

   // result held while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_block_addr))
      else $error("result changed while stalled");

   // one item in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item taken while another is in work");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_block_addr == 32'd0))
      else $error("failed item carries an address");

   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("bad state after reset");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_status     (rsp_if.status),
   .rsp_block_addr (rsp_if.block_addr)
);
